// ===== sv/lstk_pkg.sv =====
// ----------------------------------------------------------------------------
// lstk_pkg: shared types and constants for the lowest score top-k keeper
// Record layout, cell control word, request kinds and register map.
// ----------------------------------------------------------------------------
package lstk_pkg;

   localparam int MAX_KEPT_DEFAULT = 32;

   localparam int KEEP_W     = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = 6'd32;

   // register index as seen in paddr[2]
   localparam logic REG_KEEP_COUNT = 1'b0;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic [31:0] score;
      logic [15:0] start_frame;
      logic [15:0] end_frame;
      logic [15:0] frames;
      logic [15:0] utterance;
   } rec_type;

   typedef struct packed {
      logic insert;   // place the offered record, pushing larger ones right
      logic shift;    // move the whole chain one place toward cell 0
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

// ===== sv/lstk_cell.sv =====
// ----------------------------------------------------------------------------
// lstk_cell: one slot of the sorted record chain
// Holds one record, compares it with the offered score and takes its
// left neighbor, the offered record or its right neighbor as told.
// ----------------------------------------------------------------------------
module lstk_cell (
   input  logic             clock,
   input  lstk_pkg::ctl_type ctl,
   input  lstk_pkg::rec_type new_rec,
   input  lstk_pkg::rec_type left_rec,
   input  lstk_pkg::rec_type right_rec,
   input  logic             valid,
   input  logic             left_valid,
   input  logic             left_greater,
   output logic             greater,
   output lstk_pkg::rec_type rec
);
   import lstk_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;
   logic    displaced;

   // a held record with an equal score stays ahead of the new one
   assign greater   = valid && ($signed(rec_ff.score) > $signed(new_rec.score));
   // first empty slot also moves when the chain below it ends here
   assign displaced = greater || (!valid && left_valid);
   assign rec       = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctl.insert && displaced) begin
         rec_in = left_greater ? left_rec : new_rec;
      end else if (ctl.shift) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// ===== sv/lstk_csr.sv =====
// ----------------------------------------------------------------------------
// lstk_csr: configuration register block
// Holds keep_count and clamps it to the usable range 1..MAX_KEPT.
// ----------------------------------------------------------------------------
module lstk_csr #(
   parameter int MAX_KEPT = lstk_pkg::MAX_KEPT_DEFAULT,
   parameter int CNT_W    = $clog2(MAX_KEPT + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lstk_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lstk_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lstk_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic [CNT_W-1:0]                limit
);
   import lstk_pkg::*;

   logic [KEEP_W-1:0] keep_count_ff;
   logic [KEEP_W-1:0] keep_count_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_KEEP_COUNT);

   always_comb begin
      keep_count_in = keep_count_ff;
      if (wr_en) begin
         keep_count_in = pwdata[KEEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= KEEP_COUNT_RESET;
      end else begin
         keep_count_ff <= keep_count_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_KEEP_COUNT) begin
         prdata = {{(CSR_DATA_W-KEEP_W){1'b0}}, keep_count_ff};
      end
   end

   // zero acts as one, anything above the chain length as the chain length
   always_comb begin
      if (keep_count_ff == '0) begin
         limit = CNT_W'(1);
      end else if ({1'b0, keep_count_ff} > (KEEP_W+1)'(MAX_KEPT)) begin
         limit = CNT_W'(MAX_KEPT);
      end else begin
         limit = CNT_W'(keep_count_ff);
      end
   end

endmodule

// ===== sv/lowest_score_top_k_keeper.sv =====
// ----------------------------------------------------------------------------
// lowest_score_top_k_keeper: bounded top-k minimum selection
// Sorted chain of record cells with an output word register.
// ----------------------------------------------------------------------------
// An offer word (kind 0) is inserted as it is taken, and offers may follow
// each other every cycle while no drain is running: all cells compare their
// score with the offered one at once and the larger records step one cell
// to the right. A drain word (kind 1) holds off the request side until every
// kept record has left (an empty store answers with a single word with found
// low); records leave the chain one per cycle through cell 0 while the
// response side is not stalled. A new offer may be taken while the final
// drain word still waits in the output register.
module lowest_score_top_k_keeper #(
   parameter int MAX_KEPT = lstk_pkg::MAX_KEPT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic signed [31:0]              req_score,
   input  logic [15:0]                     req_start_frame,
   input  logic [15:0]                     req_end_frame,
   input  logic [15:0]                     req_utterance_frames,
   input  logic [15:0]                     req_utterance_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic signed [31:0]              rsp_out_score,
   output logic [15:0]                     rsp_out_start,
   output logic [15:0]                     rsp_out_end,
   output logic [15:0]                     rsp_out_frames,
   output logic [15:0]                     rsp_out_utterance,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lstk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lstk_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lstk_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import lstk_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEPT + 1);

   logic [CNT_W-1:0] limit;
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic             rsp_last_ff, rsp_last_in;
   rec_type          rsp_rec_ff, rsp_rec_in;

   rec_type          new_rec;
   ctl_type          ctl;
   logic             req_take;
   logic             slot_free;
   logic [CNT_W:0]   count_up;

   rec_type          cell_rec [MAX_KEPT];
   logic             cell_greater [MAX_KEPT];
   logic             cell_valid [MAX_KEPT];

   lstk_csr #(
      .MAX_KEPT (MAX_KEPT),
      .CNT_W    (CNT_W)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .limit   (limit)
   );

   assign new_rec.score       = req_score;
   assign new_rec.start_frame = req_start_frame;
   assign new_rec.end_frame   = req_end_frame;
   assign new_rec.frames      = req_utterance_frames;
   assign new_rec.utterance   = req_utterance_index;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_KEPT; gi++) begin : g_cell
         rec_type lrec, rrec;
         logic    lvalid, lgreater;

         assign cell_valid[gi] = (count_ff > CNT_W'(gi));

         if (gi == 0) begin : g_head
            assign lrec     = new_rec;
            assign lvalid   = 1'b1;
            assign lgreater = 1'b0;
         end else begin : g_body
            assign lrec     = cell_rec[gi-1];
            assign lvalid   = cell_valid[gi-1];
            assign lgreater = cell_greater[gi-1];
         end

         if (gi == MAX_KEPT - 1) begin : g_tail
            assign rrec = cell_rec[gi];
         end else begin : g_mid
            assign rrec = cell_rec[gi+1];
         end

         lstk_cell u_cell (
            .clock        (clock),
            .ctl          (ctl),
            .new_rec      (new_rec),
            .left_rec     (lrec),
            .right_rec    (rrec),
            .valid        (cell_valid[gi]),
            .left_valid   (lvalid),
            .left_greater (lgreater),
            .greater      (cell_greater[gi]),
            .rec          (cell_rec[gi])
         );
      end
   endgenerate

   assign count_up = {1'b0, count_ff} + (CNT_W+1)'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ctl          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_rec_in   = rsp_rec_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_kind == KIND_OFFER) begin
                  ctl.insert = 1'b1;
                  if (count_up > {1'b0, limit}) begin
                     count_in = limit;
                  end else begin
                     count_in = count_up[CNT_W-1:0];
                  end
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_found_in = 1'b0;
                  rsp_last_in  = 1'b1;
                  rsp_rec_in   = '0;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_found_in = 1'b1;
                  rsp_last_in  = (count_ff == CNT_W'(1));
                  rsp_rec_in   = cell_rec[0];
                  ctl.shift    = 1'b1;
                  count_in     = count_ff - CNT_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_rec_ff   <= rsp_rec_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_out_score     = rsp_rec_ff.score;
   assign rsp_out_start     = rsp_rec_ff.start_frame;
   assign rsp_out_end       = rsp_rec_ff.end_frame;
   assign rsp_out_frames    = rsp_rec_ff.frames;
   assign rsp_out_utterance = rsp_rec_ff.utterance;

endmodule
